@@ rtl/ecrs_pkg.sv @@
// Shared constants, types and register codes for the express channel route select block.
// Used by ecrs_div_pipe, ecrs_route_pick and express_channel_route_select.
// Depends on nothing else.
package ecrs_pkg;

	localparam int ROUTER_ID_BITS = 8;
	localparam int NUM_VC = 4;

	localparam int COL_W = 9;
	localparam int NI_W = 4;
	localparam int BASE_W = 6;
	localparam int PORT_W = 7;
	localparam int DIR_W = 4;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	// Restoring division, two quotient bits per pipeline stage.
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES = (ROUTER_ID_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
	localparam int CMP_W = (ROUTER_ID_BITS + 1 > COL_W) ? ROUTER_ID_BITS + 1 : COL_W;
	localparam int OFF_W = ROUTER_ID_BITS + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS     = 2'd0,
		REG_ROUTE_ORDER = 2'd1,
		REG_PORT_BASE   = 2'd2
	} cfg_reg_t;

	localparam logic ORDER_XY = 1'b0;

	localparam logic [COL_W-1:0] COLUMNS_RST = 9'd4;
	localparam logic [BASE_W-1:0] PORT_BASE_RST = 6'd12;

	localparam logic [DIR_W-1:0] EAST_BASE = 4'd0;
	localparam logic [DIR_W-1:0] WEST_BASE = 4'd3;
	localparam logic [DIR_W-1:0] SOUTH_BASE = 4'd6;
	localparam logic [DIR_W-1:0] NORTH_BASE = 4'd9;
	localparam logic [DIR_W-1:0] DIR_LAST = 4'd11;

	// One division lane: remainder and a shift register that starts as the
	// dividend and ends as the quotient.
	typedef struct packed {
		logic [ROUTER_ID_BITS-1:0] rem;
		logic [ROUTER_ID_BITS-1:0] dq;
	} div_lane_t;

	typedef struct packed {
		logic [NI_W-1:0]   ni;
		logic [NUM_VC-1:0] e2;
		logic [NUM_VC-1:0] e3;
		logic [NUM_VC-1:0] w2;
		logic [NUM_VC-1:0] w3;
		logic [NUM_VC-1:0] s2;
		logic [NUM_VC-1:0] s3;
		logic [NUM_VC-1:0] n2;
		logic [NUM_VC-1:0] n3;
	} side_t;

	typedef struct packed {
		div_lane_t cur;
		div_lane_t dst;
		side_t     side;
	} div_stage_t;

	typedef struct packed {
		logic              eject;
		logic [DIR_W-1:0]  direction;
		logic [PORT_W-1:0] eject_port;
	} route_t;

endpackage

@@ rtl/ecrs_div_pipe.sv @@
// Pipelined restoring divider that splits both router ids into row and column.
// Carries the side payload of each request alongside the division lanes.
// Depends on ecrs_pkg.
module ecrs_div_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ecrs_pkg::div_stage_t           in_item,
	input  logic [ecrs_pkg::COL_W-1:0]     divisor,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ecrs_pkg::div_stage_t           out_item
);

	localparam int D = ecrs_pkg::DIV_STAGES;
	localparam int IW = ecrs_pkg::ROUTER_ID_BITS;
	localparam int CW = ecrs_pkg::CMP_W;

	// One quotient bit: shift in the next dividend bit, subtract when it fits.
	function automatic ecrs_pkg::div_lane_t div_bit(ecrs_pkg::div_lane_t l,
			logic [ecrs_pkg::COL_W-1:0] d);
		logic [CW-1:0] trial;
		logic [CW-1:0] dd;
		ecrs_pkg::div_lane_t r;
		trial = CW'({l.rem, l.dq[IW-1]});
		dd = CW'(d);
		r.dq = {l.dq[IW-2:0], 1'b0};
		if (trial >= dd) begin
			r.rem = IW'(trial - dd);
			r.dq[0] = 1'b1;
		end else begin
			r.rem = IW'(trial);
		end
		return r;
	endfunction

	ecrs_pkg::div_stage_t stage_s [D];
	logic [D-1:0] vld_s;
	logic [D-1:0] adv;

	// A stage takes new data when it is empty or its content moves on.
	always_comb begin
		for (int k = 0; k < D; k++) begin
			if (k == D - 1) begin
				adv[k] = !vld_s[k] || out_ready;
			end else begin
				adv[k] = !vld_s[k] || adv[k+1];
			end
		end
	end

	for (genvar k = 0; k < D; k++) begin : g_stage
		ecrs_pkg::div_stage_t src;
		ecrs_pkg::div_stage_t nxt;
		logic src_vld;

		if (k == 0) begin : g_first
			assign src = in_item;
			assign src_vld = in_valid;
		end else begin : g_next
			assign src = stage_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		always_comb begin
			nxt = src;
			for (int j = 0; j < ecrs_pkg::DIV_BITS_PER_STAGE; j++) begin
				if (k * ecrs_pkg::DIV_BITS_PER_STAGE + j < IW) begin
					nxt.cur = div_bit(nxt.cur, divisor);
					nxt.dst = div_bit(nxt.dst, divisor);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				stage_s[k] <= nxt;
			end
		end
	end

	assign in_stall = !adv[0];
	assign out_valid = vld_s[D-1];
	assign out_item = stage_s[D-1];

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s[0])
		else $error("divider stalls its input while the first stage is empty");

	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[D-1] && !out_ready |=> vld_s[D-1] && $stable(stage_s[D-1]))
		else $error("divider result changed while held");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[D-1] |-> (CW'(stage_s[D-1].cur.rem) < CW'(divisor))
			&& (CW'(stage_s[D-1].dst.rem) < CW'(divisor)))
		else $error("division remainder not below the column count");

endmodule

@@ rtl/ecrs_route_pick.sv @@
// Dimension-order port choice with express hops, from column and row of both ids.
// Also forms the ejection port when the packet has arrived.
// Depends on ecrs_pkg.
module ecrs_route_pick (
	input  ecrs_pkg::div_stage_t              item,
	input  logic                              route_order,
	input  logic [ecrs_pkg::BASE_W-1:0]       port_base,
	output ecrs_pkg::route_t                  route
);

	localparam int OW = ecrs_pkg::OFF_W;
	localparam logic signed [OW-1:0] OFF_ZERO = OW'(0);
	localparam logic signed [OW-1:0] OFF_P2 = OW'(2);
	localparam logic signed [OW-1:0] OFF_P3 = OW'(3);
	localparam logic signed [OW-1:0] OFF_N2 = OW'(-2);
	localparam logic signed [OW-1:0] OFF_N3 = OW'(-3);

	function automatic logic [ecrs_pkg::DIR_W-1:0] pick_hop(
			logic signed [OW-1:0] off,
			logic [ecrs_pkg::DIR_W-1:0] base_pos,
			logic [ecrs_pkg::NUM_VC-1:0] pos2,
			logic [ecrs_pkg::NUM_VC-1:0] pos3,
			logic [ecrs_pkg::DIR_W-1:0] base_neg,
			logic [ecrs_pkg::NUM_VC-1:0] neg2,
			logic [ecrs_pkg::NUM_VC-1:0] neg3);
		logic [ecrs_pkg::DIR_W-1:0] d;
		if (off > OFF_ZERO) begin
			if (off >= OFF_P3 && |pos3) begin
				d = base_pos + ecrs_pkg::DIR_W'(2);
			end else if (off >= OFF_P2 && |pos2) begin
				d = base_pos + ecrs_pkg::DIR_W'(1);
			end else begin
				d = base_pos;
			end
		end else begin
			if (off <= OFF_N3 && |neg3) begin
				d = base_neg + ecrs_pkg::DIR_W'(2);
			end else if (off <= OFF_N2 && |neg2) begin
				d = base_neg + ecrs_pkg::DIR_W'(1);
			end else begin
				d = base_neg;
			end
		end
		return d;
	endfunction

	logic signed [OW-1:0] xoff;
	logic signed [OW-1:0] yoff;
	logic use_x;
	logic arrived;

	assign xoff = $signed({1'b0, item.dst.rem}) - $signed({1'b0, item.cur.rem});
	assign yoff = $signed({1'b0, item.dst.dq}) - $signed({1'b0, item.cur.dq});
	assign arrived = (xoff == OFF_ZERO) && (yoff == OFF_ZERO);

	// In YX order the column offset is only used once the row matches.
	assign use_x = (route_order == ecrs_pkg::ORDER_XY) ? (xoff != OFF_ZERO) : (yoff == OFF_ZERO);

	always_comb begin
		route.eject = arrived;
		route.direction = ecrs_pkg::EAST_BASE;
		route.eject_port = '0;
		if (arrived) begin
			route.eject_port = ecrs_pkg::PORT_W'(port_base) + ecrs_pkg::PORT_W'(item.side.ni);
		end else if (use_x) begin
			route.direction = pick_hop(xoff, ecrs_pkg::EAST_BASE, item.side.e2, item.side.e3,
				ecrs_pkg::WEST_BASE, item.side.w2, item.side.w3);
		end else begin
			route.direction = pick_hop(yoff, ecrs_pkg::SOUTH_BASE, item.side.s2, item.side.s3,
				ecrs_pkg::NORTH_BASE, item.side.n2, item.side.n3);
		end
	end

endmodule

@@ rtl/express_channel_route_select.sv @@
// An accepted request passes 4 divider stages of two id bits each and 1 output stage.
// Throughput: one request per cycle unless the output stalls.
// The output register holds a stalled result while the divider stages keep filling.
// Reset clears all valid bits and loads columns 4, XY order and ejection base 12.
// Top level of the route select block; depends on ecrs_pkg, ecrs_div_pipe, ecrs_route_pick.
module express_channel_route_select (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ecrs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ecrs_pkg::CFG_DATA_W-1:0]       cfg_data,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [ecrs_pkg::ROUTER_ID_BITS-1:0]   current_router,
	input  logic [ecrs_pkg::ROUTER_ID_BITS-1:0]   target_router,
	input  logic [ecrs_pkg::NI_W-1:0]             ni_position,
	input  logic [ecrs_pkg::NUM_VC-1:0]           east2_idle,
	input  logic [ecrs_pkg::NUM_VC-1:0]           east3_idle,
	input  logic [ecrs_pkg::NUM_VC-1:0]           west2_idle,
	input  logic [ecrs_pkg::NUM_VC-1:0]           west3_idle,
	input  logic [ecrs_pkg::NUM_VC-1:0]           south2_idle,
	input  logic [ecrs_pkg::NUM_VC-1:0]           south3_idle,
	input  logic [ecrs_pkg::NUM_VC-1:0]           north2_idle,
	input  logic [ecrs_pkg::NUM_VC-1:0]           north3_idle,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  eject,
	output logic [ecrs_pkg::DIR_W-1:0]            direction,
	output logic [ecrs_pkg::PORT_W-1:0]           eject_port
);

	logic [ecrs_pkg::COL_W-1:0] columns_q;
	logic route_order_q;
	logic [ecrs_pkg::BASE_W-1:0] port_base_q;
	logic [ecrs_pkg::COL_W-1:0] divisor;

	ecrs_pkg::div_stage_t in_item;
	ecrs_pkg::div_stage_t div_item;
	logic div_valid;
	logic out_ready;
	ecrs_pkg::route_t route;
	ecrs_pkg::route_t route_q;
	logic out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= ecrs_pkg::COLUMNS_RST;
			route_order_q <= ecrs_pkg::ORDER_XY;
			port_base_q <= ecrs_pkg::PORT_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ecrs_pkg::cfg_reg_t'(cfg_index))
				ecrs_pkg::REG_COLUMNS: begin
					columns_q <= cfg_data;
				end
				ecrs_pkg::REG_ROUTE_ORDER: begin
					route_order_q <= cfg_data[0];
				end
				ecrs_pkg::REG_PORT_BASE: begin
					port_base_q <= cfg_data[ecrs_pkg::BASE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A column count of zero behaves as one.
	assign divisor = (columns_q == '0) ? ecrs_pkg::COL_W'(1) : columns_q;

	always_comb begin
		in_item.cur.rem = '0;
		in_item.cur.dq = current_router;
		in_item.dst.rem = '0;
		in_item.dst.dq = target_router;
		in_item.side.ni = ni_position;
		in_item.side.e2 = east2_idle;
		in_item.side.e3 = east3_idle;
		in_item.side.w2 = west2_idle;
		in_item.side.w3 = west3_idle;
		in_item.side.s2 = south2_idle;
		in_item.side.s3 = south3_idle;
		in_item.side.n2 = north2_idle;
		in_item.side.n3 = north3_idle;
	end

	ecrs_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.divisor   (divisor),
		.out_valid (div_valid),
		.out_ready (out_ready),
		.out_item  (div_item)
	);

	ecrs_route_pick u_pick (
		.item        (div_item),
		.route_order (route_order_q),
		.port_base   (port_base_q),
		.route       (route)
	);

	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && div_valid) begin
			route_q <= route;
		end
	end

	assign out_valid = out_valid_q;
	assign eject = route_q.eject;
	assign direction = route_q.direction;
	assign eject_port = route_q.eject_port;

	a_eject_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && route_q.eject |-> route_q.direction == ecrs_pkg::EAST_BASE)
		else $error("ejected request carries a nonzero direction");

	a_route_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !route_q.eject |-> route_q.eject_port == '0
			&& route_q.direction <= ecrs_pkg::DIR_LAST)
		else $error("forwarded request has a bad direction or ejection port");

	a_columns_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == ecrs_pkg::REG_COLUMNS
			|=> columns_q == $past(cfg_data))
		else $error("column count write not taken");

endmodule
